@@ rtl/core/hsed_pkg.sv @@
// Shared types and constants for the hop symbol entropy decoder.
`default_nettype none

package hsed_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RUN_TRIGGER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_WIDTH_INITIAL = 1'd1;

  localparam logic [4:0] TRIGGER_RESET    = 5'd8;
  localparam logic [2:0] RUN_WIDTH_RESET  = 3'd4;

  // Code constants
  localparam logic [4:0] MARKER_ZEROS = 5'd24;
  localparam logic [4:0] MAX_RANK     = 5'd8;
  localparam logic [6:0] FIRST_RUN    = 7'd15;
  localparam logic [6:0] LATER_RUN    = 7'd31;
  localparam logic [6:0] RUN_SAT      = 7'd127;
  localparam logic [4:0] STREAK_MAX   = 5'd31;

  typedef struct packed {
    logic bit_in;
    logic line_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0] symbol_rank;
    logic [6:0] run_length;
    logic       invalid_code;
    logic       marker_found;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/hop_symbol_entropy_decoder_top.sv @@
// Top level of the hop symbol entropy decoder: handshakes, configuration, stage registers.
`default_nettype none

// Takes one bit of a compressed line per clock, unless in_stall holds it, and
// returns at most one (symbol_rank, run_length) pair per bit, with invalid-code
// and stream-marker flags. Sustained rate is one bit per cycle while the output
// is not stalled; a bit is held in the input register, then its result in the
// result register, and the whole decode of a bit is one combinational pass
// between them. Bits that end no code produce no result. Configuration writes
// take effect at once for the trigger and at the next line_start or count-width
// reload for the initial width; write them only while the block is idle.
module hop_symbol_entropy_decoder_top
  import hsed_pkg::*;
#(
  parameter int MAX_RUN_WIDTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [4:0] trig_r;
  logic [2:0] winit_r;
  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  logic       adv;
  logic       res_vld;
  out_item_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r  <= TRIGGER_RESET;
      winit_r <= RUN_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ZERO_RUN_TRIGGER:  trig_r  <= cfg_data[4:0];
        CFG_RUN_WIDTH_INITIAL: winit_r <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // the held bit moves on when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  hsed_core #(
    .MAX_RUN_WIDTH(MAX_RUN_WIDTH)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (adv),
    .item              (in_item_r),
    .zero_run_trigger  (trig_r),
    .run_width_initial (winit_r),
    .res_vld           (res_vld),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> adv)
    else $error("result produced without a bit advancing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !adv)
    else $error("held bit advanced over a stalled result");

  a_held_bit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("held input bit dropped");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv))
    else $error("result appeared without a decoded bit");

endmodule

`default_nettype wire

@@ rtl/core/hsed_core.sv @@
// Decoder state and single-pass bit decode for the hop symbol entropy decoder.
`default_nettype none

module hsed_core
  import hsed_pkg::*;
#(
  parameter int MAX_RUN_WIDTH = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire in_item_t   item,
  input  wire logic [4:0] zero_run_trigger,
  input  wire logic [2:0] run_width_initial,
  output logic            res_vld,
  output out_item_t       res
);

  localparam int RWW = $clog2(MAX_RUN_WIDTH + 1);
  localparam int RVW = MAX_RUN_WIDTH;
  // count width after reset, from the register's reset value
  localparam logic [RWW-1:0] RW_RESET = (MAX_RUN_WIDTH < int'(RUN_WIDTH_RESET)) ?
                                        RWW'(MAX_RUN_WIDTH) : RWW'(RUN_WIDTH_RESET);

  typedef enum logic [1:0] {
    MODE_VLC  = 2'd0,
    MODE_PRE  = 2'd1,
    MODE_RUN1 = 2'd2,
    MODE_RUN2 = 2'd3
  } mode_t;

  mode_t            mode_r, mode_nxt, mode_e;
  logic [4:0]       zc_r, zc_nxt, zc_e;
  logic [4:0]       streak_r, streak_nxt, streak_e;
  logic [RWW-1:0]   rw_r, rw_nxt, rw_e;
  logic [RVW-1:0]   rv_r, rv_nxt, rv_e;
  logic [RWW-1:0]   rbl_r, rbl_nxt, rbl_e;

  logic [3:0]       sw_wide;
  logic [RWW-1:0]   start_w;
  logic [RVW-1:0]   rv_shift;
  logic [7:0]       rv8;
  logic [4:0]       rank;
  logic [4:0]       zc_inc;
  logic             emit;

  // clamp of the initial count width: 0 acts as 1, capped at the maximum
  always_comb begin
    if (run_width_initial == 3'd0) begin
      sw_wide = 4'd1;
    end else if (4'(run_width_initial) > 4'(MAX_RUN_WIDTH)) begin
      sw_wide = 4'(MAX_RUN_WIDTH);
    end else begin
      sw_wide = 4'(run_width_initial);
    end
  end
  assign start_w = RWW'(sw_wide);

  // line_start resets the state (count width to its initial value) before the bit is used
  assign mode_e   = item.line_start ? MODE_VLC : mode_r;
  assign zc_e     = item.line_start ? 5'd0 : zc_r;
  assign streak_e = item.line_start ? 5'd0 : streak_r;
  assign rw_e     = item.line_start ? start_w : rw_r;
  assign rv_e     = item.line_start ? '0 : rv_r;
  assign rbl_e    = item.line_start ? '0 : rbl_r;

  assign rv_shift = {rv_e[RVW-2:0], item.bit_in};
  assign rv8      = 8'(rv_shift);
  assign zc_inc   = zc_e + 5'd1;
  assign rank     = zc_e + ((mode_e == MODE_PRE) ? 5'd1 : 5'd0);

  always_comb begin
    mode_nxt   = mode_e;
    zc_nxt     = zc_e;
    streak_nxt = streak_e;
    rw_nxt     = rw_e;
    rv_nxt     = rv_e;
    rbl_nxt    = rbl_e;
    emit       = 1'b0;
    res        = '0;

    if (rbl_e != '0) begin
      // shifting in a count field
      rv_nxt  = rv_shift;
      rbl_nxt = rbl_e - RWW'(1);
      if (rbl_e == RWW'(1)) begin
        if (mode_e == MODE_RUN2) begin
          rw_nxt = start_w;
        end
        mode_nxt = MODE_PRE;
        zc_nxt   = 5'd0;
        if (rv_shift != '0) begin
          emit           = 1'b1;
          res.run_length = rv8[7] ? RUN_SAT : rv8[6:0];
        end
      end
    end else begin
      case (mode_e)
        MODE_RUN1: begin
          if (!item.bit_in) begin
            rv_nxt  = '0;
            rbl_nxt = rw_e;
          end else begin
            if (rw_e < RWW'(MAX_RUN_WIDTH)) begin
              rw_nxt = rw_e + RWW'(1);
            end
            mode_nxt       = MODE_RUN2;
            emit           = 1'b1;
            res.run_length = FIRST_RUN;
          end
        end
        MODE_RUN2: begin
          if (!item.bit_in) begin
            rv_nxt  = '0;
            rbl_nxt = rw_e;
          end else begin
            emit           = 1'b1;
            res.run_length = LATER_RUN;
          end
        end
        MODE_VLC, MODE_PRE: begin
          if (!item.bit_in) begin
            if (zc_inc >= MARKER_ZEROS) begin
              zc_nxt           = 5'd0;
              emit             = 1'b1;
              res.marker_found = 1'b1;
            end else begin
              zc_nxt = zc_inc;
            end
          end else begin
            zc_nxt         = 5'd0;
            emit           = 1'b1;
            res.run_length = 7'd1;
            if (rank > MAX_RANK) begin
              streak_nxt       = 5'd0;
              mode_nxt         = MODE_VLC;
              res.invalid_code = 1'b1;
            end else if (mode_e == MODE_PRE) begin
              streak_nxt      = 5'd0;
              mode_nxt        = MODE_VLC;
              res.symbol_rank = rank[3:0];
            end else begin
              res.symbol_rank = rank[3:0];
              if (rank == 5'd0) begin
                streak_nxt = (streak_e < STREAK_MAX) ? streak_e + 5'd1 : streak_e;
              end else begin
                streak_nxt = 5'd0;
              end
              if (zero_run_trigger != 5'd0 && streak_nxt == zero_run_trigger) begin
                mode_nxt = MODE_RUN1;
              end
            end
          end
        end
        default: begin
          mode_nxt = MODE_VLC;
        end
      endcase
    end
  end

  assign res_vld = step & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_VLC;
      zc_r     <= 5'd0;
      streak_r <= 5'd0;
      rw_r     <= RW_RESET;
      rv_r     <= '0;
      rbl_r    <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      zc_r     <= zc_nxt;
      streak_r <= streak_nxt;
      rw_r     <= rw_nxt;
      rv_r     <= rv_nxt;
      rbl_r    <= rbl_nxt;
    end
  end

endmodule

`default_nettype wire
